// File: rtl/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the prime sieve
// Payload structs for both channels, the remainder unit's request and
// response groups, and the default store depth.
// ----------------------------------------------------------------------------
package pps_pkg;

    // candidate and prime width, fixed by the channel payload
    localparam int VALUE_WIDTH = 16;

    // default number of store cells
    localparam int NUM_CELLS_DEF = 16;

    // input transfer payload
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] candidate;
        logic                   last;
    } t_in;

    // output transfer payload
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] prime;
        logic                   store_full;
    } t_out;

    // request to the remainder unit
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } t_div_req;

    // status from the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_div_rsp;

endpackage

// File: rtl/pipelined_prime_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipelined_prime_sieve: prime filter over a candidate stream
// Tests each candidate against the stored primes and reports survivors.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid, i_in, o_in_stall) carries a candidate and a
//   last flag. The block takes one candidate at a time; o_in_stall is high
//   from the transfer until the item is finished.
//   Output channel (o_out_valid, o_out, i_out_stall) carries the prime and
//   store_full. A divided candidate produces no output transfer.
//   For each stored prime the sequencer reads the RAM, loads the divisor
//   and waits for the bit-serial remainder unit to step through the
//   candidate bits and signal done; a stored zero skips the division, and
//   the scan ends early when a divisor is found.
//   A surviving candidate is written to the next free cell; with all cells
//   used it is reported with store_full set and not stored.
//   While the receiver stalls, the result holds in the output register and
//   no new candidate is taken. After an item with last set, the prime count
//   returns to zero.
//   Reset clears the count and the sequencer; the store needs no clearing.
// ----------------------------------------------------------------------------
module pipelined_prime_sieve
    import pps_pkg::*;
#(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out,
    input  logic i_out_stall
);

    localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CW = $clog2(NUM_CELLS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_LOAD = 6'b000100,
        S_DIV  = 6'b001000,
        S_EMIT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_idx, n_idx;
    logic [VALUE_WIDTH-1:0] r_cand, n_cand;
    logic                   r_last, n_last;
    t_out                   r_out, n_out;

    logic                   ram_we;
    logic                   ram_rd;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    t_div_req               div_req;
    t_div_rsp               div_rsp;
    logic                   idx_final;
    logic                   full;

    // prime store
    pps_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NUM_CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_cand),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rdata)
    );

    // single remainder unit, used for every stored prime
    pps_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign idx_final = ((CW'(r_idx) + 1'b1) == r_count);
    assign full      = (r_count == CW'(NUM_CELLS));

    // sequencer
    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_idx            = r_idx;
        n_cand           = r_cand;
        n_last           = r_last;
        n_out            = r_out;
        ram_we           = 1'b0;
        ram_rd           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_cand;
        div_req.divisor  = ram_rdata;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cand  = i_in.candidate;
                    n_last  = i_in.last;
                    n_idx   = '0;
                    n_state = (r_count == '0) ? S_EMIT : S_READ;
                end
            end
            S_READ: begin
                ram_rd  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // a stored zero divides only zero
                if (ram_rdata == '0) begin
                    if (r_cand == '0) begin
                        n_state = S_IDLE;
                        if (r_last) n_count = '0;
                    end else if (idx_final) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem_zero) begin
                        n_state = S_IDLE;
                        if (r_last) n_count = '0;
                    end else if (idx_final) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_EMIT: begin
                n_out.prime      = r_cand;
                n_out.store_full = full;
                if (!full) begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_last) n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // item and result registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cand <= n_cand;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_CELLS))
        else $error("prime count exceeds store depth");

    // remainder unit runs only while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_state == S_DIV))
        else $error("remainder unit busy outside divide state");

    // reads address only cells already written
    a_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (CW'(r_idx) < r_count))
        else $error("store read beyond prime count");

    // an accepted item blocks the next one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while item in progress");
`endif

endmodule

// File: rtl/pps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pps_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; reports whether the
// remainder is zero. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module pps_rem
    import pps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int SW = $clog2(VALUE_WIDTH);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [SW-1:0]          r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_shift, n_shift;
    logic [VALUE_WIDTH-1:0] r_div, n_div;
    logic [VALUE_WIDTH:0]   partial;
    logic [VALUE_WIDTH:0]   diff;

    // one restoring step: bring down a bit, subtract if it fits
    always_comb begin
        partial = {r_rem, r_shift[VALUE_WIDTH-1]};
        diff    = partial - {1'b0, r_div};
    end

    // step sequencing
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_div   = r_div;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = SW'(VALUE_WIDTH - 1);
            n_rem   = '0;
            n_shift = i_req.dividend;
            n_div   = i_req.divisor;
        end else if (r_busy) begin
            n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
            n_rem   = diff[VALUE_WIDTH] ? partial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            n_cnt   = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_div   <= n_div;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pipelined prime sieve
// Streams candidates through the input channel and predicts each reported
// prime from its own copy of the store and count. A short directed pass
// covers zero, one, repeats and a full store. Random ascending runs,
// descending runs and noise follow, with gaps and output stalls in bursts.
// ----------------------------------------------------------------------------
module tb_top;
    import pps_pkg::*;

    localparam int     CELLS        = NUM_CELLS_DEF;
    localparam int     RANDOM_ITEMS = 1600;
    localparam int     CALM_FROM    = 1400;
    localparam int     ITEM_LATENCY = 3 + 19 * CELLS + 16;
    localparam longint CYCLE_LIMIT  = 3000000;
    localparam int     MAX_PRINTED  = 40;

    // prime store predictor with its queue of pending primes
    class sieve_model;
        logic [VALUE_WIDTH-1:0] primes [CELLS];
        int unsigned            n_primes;
        t_out                   expected_primes [$];
        int unsigned            n_checked;
        int unsigned            n_full;

        // predict the outcome of one accepted candidate
        function void note_candidate(t_in item);
            t_out res;
            bit   survived;
            survived = 1'b1;
            for (int i = 0; i < n_primes; i++) begin
                // a stored zero only divides zero
                if (primes[i] == '0 ? item.candidate == '0
                                    : (item.candidate % primes[i]) == '0) begin
                    survived = 1'b0;
                    break;
                end
            end
            if (survived) begin
                res.prime      = item.candidate;
                res.store_full = (n_primes >= CELLS);
                if (!res.store_full) begin
                    primes[n_primes] = item.candidate;
                    n_primes++;
                end
                expected_primes.push_back(res);
            end
            if (item.last) begin
                n_primes = 0;
            end
        endfunction

        // compare one output transfer with the oldest pending prime
        function string check_prime(t_out got);
            t_out  want;
            string msg;
            if (expected_primes.size() == 0) begin
                return $sformatf(" unexpected transfer: prime %0d store_full %0b",
                                 got.prime, got.store_full);
            end
            want = expected_primes.pop_front();
            n_checked++;
            if (want.store_full) begin
                n_full++;
            end
            msg = "";
            if (got.prime !== want.prime) begin
                msg = {msg, $sformatf(" prime %0d, expected %0d", got.prime, want.prime)};
            end
            if (got.store_full !== want.store_full) begin
                msg = {msg, $sformatf(" store_full %0b, expected %0b",
                                      got.store_full, want.store_full)};
            end
            return msg;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    t_in  i_in;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;
    logic i_out_stall;

    sieve_model book = new();

    bit                 idle_on = 1'b0;
    longint             cycle_count = 0;
    int unsigned        n_errors = 0;
    int unsigned        n_sent = 0;
    int unsigned        n_clears = 0;
    logic [VALUE_WIDTH-1:0] prev_cand = '0;

    pipelined_prime_sieve #(
        .NUM_CELLS (CELLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED) begin
            $display("mismatch at cycle %0d:%s", cycle_count, msg);
        end
    endtask

    // one input transfer, with an optional gap before it
    task automatic send_item(logic [VALUE_WIDTH-1:0] cand, logic last_flag);
        t_in item;
        item.candidate = cand;
        item.last      = last_flag;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        book.note_candidate(item);
        n_sent++;
        prev_cand = cand;
        if (last_flag) begin
            n_clears++;
        end
    endtask

    // ascending run, cleared at its end unless left open
    task automatic send_ascending(logic [VALUE_WIDTH-1:0] base, int unsigned len,
                                  bit close_run);
        for (int unsigned k = 0; k < len; k++) begin
            send_item(VALUE_WIDTH'(base + k), close_run && (k == len - 1));
        end
    endtask

    // receiver: check output transfers and stall in bursts
    initial begin
        int unsigned stall_left;
        string       msg;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                msg = book.check_prime(o_out);
                if (msg != "") begin
                    report(msg);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned            kind;
        int unsigned            len;
        int unsigned            step;
        int unsigned            drain;
        logic [VALUE_WIDTH-1:0] base;
        logic [VALUE_WIDTH-1:0] picks [6];

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        // zero on an empty store, then zero against a stored zero
        send_item(16'd0, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'hFFFF, 1'b1);
        // one divides everything after it
        send_item(16'd1, 1'b0);
        send_item(16'hFFFF, 1'b1);
        // repeated candidate
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b1);
        // fill every cell, then overflow
        picks = '{16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13};
        foreach (picks[i]) send_item(picks[i], 1'b0);
        send_item(16'd17, 1'b0);
        send_item(16'd19, 1'b0);
        send_item(16'd23, 1'b0);
        send_item(16'd29, 1'b0);
        send_item(16'd31, 1'b0);
        send_item(16'd37, 1'b0);
        send_item(16'd41, 1'b0);
        send_item(16'd43, 1'b0);
        send_item(16'd47, 1'b0);
        send_item(16'd53, 1'b0);
        send_item(16'd59, 1'b0);
        send_item(16'd4, 1'b1);

        // random part: mostly ascending runs, some noise and descending runs
        while (n_sent < RANDOM_ITEMS + 25) begin
            idle_on = (n_sent < CALM_FROM) && ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                len = $urandom_range(1, 70);
                if ($urandom_range(0, 4) != 0) begin
                    base = 16'd2;
                end else begin
                    base = VALUE_WIDTH'($urandom_range(2, 65535 - len));
                end
                send_ascending(base, len, $urandom_range(0, 5) != 0);
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(VALUE_WIDTH'($urandom_range(0, 65535)),
                              $urandom_range(0, 3) == 0);
                end
            end else if (kind == 8) begin
                picks = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'hFFFE, prev_cand};
                repeat ($urandom_range(1, 4)) begin
                    send_item(picks[$urandom_range(0, 5)], $urandom_range(0, 2) == 0);
                end
            end else begin
                base = VALUE_WIDTH'($urandom_range(30, 65535));
                step = $urandom_range(1, 3);
                len  = $urandom_range(1, 8);
                for (int unsigned k = 0; k < len; k++) begin
                    send_item(VALUE_WIDTH'(base - k * step), k == len - 1);
                end
            end
        end
        i_in_valid <= 1'b0;
        idle_on = 1'b0;

        // drain, then let a late stray transfer show up
        drain = 0;
        while (book.expected_primes.size() != 0 && drain < 20 * ITEM_LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (ITEM_LATENCY) @(posedge i_clk);
        if (book.expected_primes.size() != 0) begin
            report($sformatf(" %0d primes never reported", book.expected_primes.size()));
        end

        $display("sent %0d candidates with %0d clears; checked %0d primes, %0d with a full store",
                 n_sent, n_clears, book.n_checked, book.n_full);
        $display("%0d mismatches in %0d cycles", n_errors, cycle_count);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pps_pkg.sv
rtl/pps_ram.sv
rtl/pps_rem.sv
rtl/pipelined_prime_sieve.sv
sim/tb_top.sv
